// File: hdl/mcsfs_pkg.sv
// ----------------------------------------------------------------------------
// mcsfs_pkg
// Shared types, codes and defaults of the multi-CPU SRTF/FIFO scheduler.
// ----------------------------------------------------------------------------
package mcsfs_pkg;

	localparam int MAX_CPUS_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TIME_BITS_DEF   = 16;

	localparam int ID_W    = 8;
	localparam int REM_W   = 16;
	localparam int SLICE_W = 17;
	localparam int CFG_IW  = 2;

	localparam logic [SLICE_W-1:0] SLICE_NONE = '1;

	typedef enum logic [2:0] {
		OP_IDLE    = 3'd0,
		OP_PREEMPT = 3'd1,
		OP_YIELD   = 3'd2,
		OP_TERM    = 3'd3,
		OP_WAKE    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_DISPATCH = 2'd0,
		ACT_RUN_IDLE = 2'd1,
		ACT_PREEMPT  = 2'd2,
		ACT_FULL     = 2'd3
	} action_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_SRTF  = 2'd0,
		CFG_NCPU  = 2'd1,
		CFG_SLICE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WAKE,
		S_PSCAN,
		S_SCHED,
		S_SCAN,
		S_TAKE,
		S_GRAB,
		S_SHIFT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [2:0]       cpu_index;
		logic [ID_W-1:0]  proc_id;
		logic [REM_W-1:0] remaining;
	} in_item_t;

	typedef struct packed {
		action_t            action;
		logic [2:0]         target_cpu;
		logic [ID_W-1:0]    chosen_id;
		logic [SLICE_W-1:0] granted_slice;
	} out_item_t;

endpackage

// File: hdl/mcsfs_ifs.sv
// ----------------------------------------------------------------------------
// mcsfs channel interfaces
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface mcsfs_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [2:0]  cpu_index;
	logic [7:0]  proc_id;
	logic [15:0] remaining;

	modport source (output valid, op, cpu_index, proc_id, remaining, input ready);
	modport sink (input valid, op, cpu_index, proc_id, remaining, output ready);
endinterface

interface mcsfs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  target_cpu;
	logic [7:0]  chosen_id;
	logic [16:0] granted_slice;

	modport source (output valid, action, target_cpu, chosen_id, granted_slice, input ready);
	modport sink (input valid, action, target_cpu, chosen_id, granted_slice, output ready);
endinterface

interface mcsfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/mcsfs_ram.sv
// ----------------------------------------------------------------------------
// mcsfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcsfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// File: hdl/mcsfs_core.sv
// ----------------------------------------------------------------------------
// mcsfs_core
// Event sequencer: queue scan, compaction and CPU table updates.
// ----------------------------------------------------------------------------
module mcsfs_core #(
	parameter int MAX_CPUS    = mcsfs_pkg::MAX_CPUS_DEF,
	parameter int QUEUE_DEPTH = mcsfs_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = mcsfs_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_srtf,
	input  logic [$clog2(MAX_CPUS+1)-1:0]         cfg_ncpu,
	input  logic [mcsfs_pkg::SLICE_W-1:0]         cfg_slice,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  mcsfs_pkg::in_item_t                   item,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output mcsfs_pkg::out_item_t                  res,
	output logic                                  ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0]        ram_wr_addr,
	output logic [mcsfs_pkg::ID_W+TIME_BITS-1:0]  ram_wr_data,
	output logic [$clog2(QUEUE_DEPTH)-1:0]        ram_rd_addr,
	input  logic [mcsfs_pkg::ID_W+TIME_BITS-1:0]  ram_rd_data
);
	import mcsfs_pkg::*;

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH+1);
	localparam int CW   = $clog2(MAX_CPUS+1);
	localparam int CIW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int IW   = (CNTW > CW) ? CNTW : CW;

	state_t               state_q, state_d;
	in_item_t             item_q;
	logic [CIW-1:0]       cpu_q;
	logic [CNTW-1:0]      count_q;
	logic [IW-1:0]        idx_q;
	logic [AW-1:0]        pick_q;
	logic [TIME_BITS-1:0] best_t_q;
	logic [ID_W-1:0]      best_id_q;
	logic [CIW-1:0]       best_cpu_q;
	logic                 found_q;
	out_item_t            res_q;
	logic [MAX_CPUS-1:0]  run_valid_q;
	logic [MAX_CPUS-1:0]  wait_q;
	logic [ID_W-1:0]      run_id_q   [MAX_CPUS];
	logic [TIME_BITS-1:0] run_time_q [MAX_CPUS];

	logic [TIME_BITS-1:0] rem_t;
	logic [ID_W-1:0]      rd_id;
	logic [TIME_BITS-1:0] rd_t;
	logic [CIW-1:0]       run_addr;
	logic                 run_v;
	logic [ID_W-1:0]      run_id;
	logic [TIME_BITS-1:0] run_t;
	logic                 q_full, q_empty, ev_bad, is_wake, pre_live;
	logic                 wfound;
	logic [CIW-1:0]       wcpu;
	logic                 pend, scan_end, sh_more;
	logic [SLICE_W-1:0]   granted;

	assign rem_t    = TIME_BITS'(item_q.remaining);
	assign rd_id    = ram_rd_data[ID_W+TIME_BITS-1 -: ID_W];
	assign rd_t     = ram_rd_data[TIME_BITS-1:0];
	assign run_addr = (state_q == S_PSCAN) ? CIW'(idx_q) : cpu_q;
	assign run_v    = run_valid_q[run_addr];
	assign run_id   = run_id_q[run_addr];
	assign run_t    = run_time_q[run_addr];
	assign q_full   = (count_q == CNTW'(QUEUE_DEPTH));
	assign q_empty  = (count_q == '0);
	assign is_wake  = (item_q.op == OP_WAKE);
	assign ev_bad   = (item_q.op > OP_WAKE) || (int'(item_q.cpu_index) >= int'(cfg_ncpu));
	assign pre_live = (item_q.op == OP_PREEMPT) && run_v;
	assign pend     = (idx_q == IW'(cfg_ncpu));
	assign scan_end = (idx_q == IW'(count_q));
	assign sh_more  = (idx_q < IW'(count_q));
	assign granted  = cfg_slice[SLICE_W-1] ? SLICE_NONE : cfg_slice;

	// lowest waiting cpu in use
	always_comb begin
		wfound = 1'b0;
		wcpu   = '0;
		for (int i = 0; i < MAX_CPUS; i++) begin
			if (!wfound && (i < int'(cfg_ncpu)) && wait_q[i]) begin
				wfound = 1'b1;
				wcpu   = CIW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (is_wake) state_d = q_full ? S_EMIT : S_WAKE;
				else if (ev_bad) state_d = S_IDLE;
				else if (item_q.op == OP_IDLE) state_d = q_empty ? S_IDLE : S_SCHED;
				else if (pre_live && q_full) state_d = S_EMIT;
				else state_d = S_SCHED;
			end
			S_WAKE: begin
				if (wfound) state_d = S_SCHED;
				else if (!cfg_srtf) state_d = S_IDLE;
				else state_d = S_PSCAN;
			end
			S_PSCAN: begin
				if (pend) state_d = (found_q && best_t_q > rem_t) ? S_EMIT : S_IDLE;
				else if (!run_v) state_d = S_IDLE;
			end
			S_SCHED: begin
				if (q_empty) state_d = S_EMIT;
				else state_d = cfg_srtf ? S_SCAN : S_TAKE;
			end
			S_SCAN:   if (scan_end) state_d = S_TAKE;
			S_TAKE:   state_d = S_GRAB;
			S_GRAB:   state_d = S_SHIFT;
			S_SHIFT:  if (!sh_more) state_d = S_EMIT;
			S_EMIT:   if (res_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		ram_we      = 1'b0;
		ram_wr_addr = AW'(count_q);
		ram_wr_data = {item_q.proc_id, rem_t};
		ram_rd_addr = '0;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_DECODE: begin
				if (is_wake) begin
					ram_we = !q_full;
				end else if (!ev_bad && pre_live && !q_full) begin
					ram_we      = 1'b1;
					ram_wr_data = {run_id, rem_t};
				end
			end
			S_SCAN:   ram_rd_addr = AW'(idx_q);
			S_TAKE:   ram_rd_addr = pick_q;
			S_GRAB:   ram_rd_addr = pick_q + AW'(1);
			S_SHIFT: begin
				ram_rd_addr = AW'(idx_q + IW'(1));
				ram_we      = sh_more;
				ram_wr_addr = AW'(idx_q - IW'(1));
				ram_wr_data = ram_rd_data;
			end
			S_EMIT:   res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			run_valid_q <= '0;
			wait_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_DECODE: begin
					if (is_wake) begin
						if (!q_full) count_q <= count_q + CNTW'(1);
					end else if (!ev_bad) begin
						wait_q[cpu_q]      <= 1'b0;
						run_valid_q[cpu_q] <= 1'b0;
						if (item_q.op == OP_IDLE && q_empty) begin
							wait_q[cpu_q] <= 1'b1;
						end else if (pre_live && !q_full) begin
							count_q <= count_q + CNTW'(1);
						end
					end
				end
				S_WAKE: begin
					if (wfound) wait_q[wcpu] <= 1'b0;
				end
				S_SCHED: begin
					if (q_empty) run_valid_q[cpu_q] <= 1'b0;
				end
				S_GRAB:  run_valid_q[cpu_q] <= 1'b1;
				S_SHIFT: begin
					if (!sh_more) count_q <= count_q - CNTW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q <= item;
				cpu_q  <= CIW'(item.cpu_index);
			end
			S_DECODE: begin
				idx_q    <= '0;
				found_q  <= 1'b0;
				best_t_q <= '0;
				if (is_wake) begin
					res_q <= '{ACT_FULL, 3'd0, item_q.proc_id, SLICE_NONE};
				end else begin
					res_q <= '{ACT_FULL, item_q.cpu_index, run_id, SLICE_NONE};
				end
			end
			S_WAKE: begin
				if (wfound) cpu_q <= wcpu;
			end
			S_PSCAN: begin
				idx_q <= idx_q + IW'(1);
				if (!pend && run_v && run_t > best_t_q) begin
					best_t_q   <= run_t;
					best_cpu_q <= run_addr;
					best_id_q  <= run_id;
					found_q    <= 1'b1;
				end
				res_q <= '{ACT_PREEMPT, 3'(best_cpu_q), best_id_q, SLICE_NONE};
			end
			S_SCHED: begin
				idx_q  <= IW'(1);
				pick_q <= '0;
				res_q  <= '{ACT_RUN_IDLE, 3'(cpu_q), '0, SLICE_NONE};
			end
			S_SCAN: begin
				if (idx_q == IW'(1) || rd_t < best_t_q) begin
					best_t_q <= rd_t;
					pick_q   <= AW'(idx_q - IW'(1));
				end
				if (!scan_end) idx_q <= idx_q + IW'(1);
			end
			S_GRAB: begin
				run_id_q[cpu_q]   <= rd_id;
				run_time_q[cpu_q] <= rd_t;
				res_q <= '{ACT_DISPATCH, 3'(cpu_q), rd_id, granted};
				idx_q <= IW'(pick_q) + IW'(1);
			end
			S_SHIFT: begin
				if (sh_more) idx_q <= idx_q + IW'(1);
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_wait_not_run: assert property (@(posedge clk) disable iff (!arst_n)
		(wait_q & run_valid_q) == '0)
		else $error("cpu both waiting and running");

	a_dispatch_running: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.action == ACT_DISPATCH) |-> run_valid_q[cpu_q])
		else $error("dispatch to a cpu not marked running");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= IW'(count_q)))
		else $error("queue scan past count");

	a_shift_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && !sh_more) |=> (count_q == $past(count_q) - CNTW'(1)))
		else $error("compaction did not shrink queue");
endmodule

// File: hdl/multi_cpu_srtf_fifo_scheduler_top.sv
// ----------------------------------------------------------------------------
// multi_cpu_srtf_fifo_scheduler_top
// CPU scheduler with a bounded ready queue, FIFO or SRTF dispatch.
// ----------------------------------------------------------------------------
// Events (idle, preempt, yield, terminate, wake-up) arrive on in_ch; each
// gives at most one result item on out_ch (dispatch, run idle, force
// preempt, queue full). Registers are written on cfg: 0 SRTF mode, 1 CPUs
// in use, 2 slice length; cfg is always ready, write only while idle.
// One event is handled at a time. Each is accepted, then decoded; a wake-up
// adds a waiting-CPU check; a dispatch then runs an SRTF scan over every
// queue entry, takes and grabs the chosen one and compacts the entries behind
// it, all through the single queue RAM; a wake-up preempt check steps through
// the CPUs in use, then emits a result if it found one.
// Results sit in an output register; while the receiver stalls one item waits
// there and the next event is still handled, and its result holds the block
// in its result state with in_ch.ready low until the receiver takes an item.
// Reset clears the queue count, running and waiting marks and restores
// register defaults; queue RAM contents need no clearing.
// ----------------------------------------------------------------------------
module multi_cpu_srtf_fifo_scheduler_top #(
	parameter int MAX_CPUS    = mcsfs_pkg::MAX_CPUS_DEF,
	parameter int QUEUE_DEPTH = mcsfs_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = mcsfs_pkg::TIME_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mcsfs_cfg_if.sink   cfg,
	mcsfs_in_if.sink    in_ch,
	mcsfs_out_if.source out_ch
);
	import mcsfs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(MAX_CPUS+1);
	localparam int EW = ID_W + TIME_BITS;

	logic               srtf_q;
	logic [3:0]         ncpu_raw_q;
	logic [SLICE_W-1:0] slice_q;
	logic [CW-1:0]      ncpu;
	logic               out_valid_q;
	out_item_t          out_q;
	in_item_t           item;
	out_item_t          res;
	logic               res_valid, res_ready;
	logic               ram_we;
	logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
	logic [EW-1:0]      ram_wr_data, ram_rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtf_q     <= 1'b0;
			ncpu_raw_q <= 4'd1;
			slice_q    <= SLICE_NONE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SRTF:  srtf_q     <= cfg.data[0];
				CFG_NCPU:  ncpu_raw_q <= cfg.data[3:0];
				CFG_SLICE: slice_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ncpu = (ncpu_raw_q == '0) ? CW'(1)
		: (int'(ncpu_raw_q) > MAX_CPUS) ? CW'(MAX_CPUS) : CW'(ncpu_raw_q);

	assign item = '{in_ch.op, in_ch.cpu_index, in_ch.proc_id, in_ch.remaining};

	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.action        = out_q.action;
	assign out_ch.target_cpu    = out_q.target_cpu;
	assign out_ch.chosen_id     = out_q.chosen_id;
	assign out_ch.granted_slice = out_q.granted_slice;

	mcsfs_core #(
		.MAX_CPUS    (MAX_CPUS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_srtf    (srtf_q),
		.cfg_ncpu    (ncpu),
		.cfg_slice   (slice_q),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.item        (item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_we      (ram_we),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	mcsfs_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);
endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// scheduler testbench
// Drives scheduling events into the multi-CPU scheduler under FIFO and SRTF
// settings, predicts each dispatch, idle, preempt order and drop, and checks
// every result item in order under random sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
	import mcsfs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mcsfs_cfg_if cfg();
	mcsfs_in_if  in_ch();
	mcsfs_out_if out_ch();

	multi_cpu_srtf_fifo_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	typedef struct {
		action_t            action;
		logic [2:0]         target_cpu;
		logic [7:0]         chosen_id;
		logic [SLICE_W-1:0] granted_slice;
	} sched_result_t;

	// scheduler state
	logic [7:0]         q_ids[$];
	logic [15:0]        q_times[$];
	logic               run_valid[8];
	logic [7:0]         run_ids[8];
	logic [15:0]        run_times[8];
	logic               waiting[8];
	logic               srtf;
	logic [3:0]         ncpu;
	logic [SLICE_W-1:0] slice_len;

	sched_result_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	initial forever #10 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int active_cpus();
		if (ncpu < 1) return 1;
		if (ncpu > 8) return 8;
		return ncpu;
	endfunction

	function automatic void push_result(action_t a, int c, logic [7:0] id,
	                                    logic [SLICE_W-1:0] s);
		sched_result_t r;
		r.action = a;
		r.target_cpu = c[2:0];
		r.chosen_id = id;
		r.granted_slice = s;
		expected_results.push_back(r);
	endfunction

	function automatic void dispatch_cpu(int c);
		int pick;
		pick = 0;
		if (q_ids.size() == 0) begin
			run_valid[c] = 1'b0;
			push_result(ACT_RUN_IDLE, c, 8'd0, SLICE_NONE);
			return;
		end
		if (srtf)
			for (int i = 1; i < q_ids.size(); i++)
				if (q_times[i] < q_times[pick]) pick = i;
		run_valid[c] = 1'b1;
		run_ids[c] = q_ids[pick];
		run_times[c] = q_times[pick];
		q_ids.delete(pick);
		q_times.delete(pick);
		push_result(ACT_DISPATCH, c, run_ids[c],
			slice_len[SLICE_W-1] ? SLICE_NONE : slice_len);
	endfunction

	function automatic void predict_event(op_t op, int c, logic [7:0] pid,
	                                      logic [15:0] rem);
		int n;
		logic [15:0] best_time;
		int best_cpu;
		logic found;
		n = active_cpus();
		best_time = 0;
		best_cpu = 0;
		found = 1'b0;
		if (op == OP_WAKE) begin
			if (q_ids.size() >= QUEUE_DEPTH_DEF) begin
				push_result(ACT_FULL, 0, pid, SLICE_NONE);
				return;
			end
			q_ids.push_back(pid);
			q_times.push_back(rem);
			for (int i = 0; i < n; i++)
				if (waiting[i]) begin
					waiting[i] = 1'b0;
					dispatch_cpu(i);
					return;
				end
			if (!srtf) return;
			for (int i = 0; i < n; i++) begin
				if (!run_valid[i]) return;
				if (run_times[i] > best_time) begin
					best_time = run_times[i];
					best_cpu = i;
					found = 1'b1;
				end
			end
			if (found && best_time > rem)
				push_result(ACT_PREEMPT, best_cpu, run_ids[best_cpu], SLICE_NONE);
			return;
		end
		if (op > OP_WAKE || c >= n) return;
		waiting[c] = 1'b0;
		if (op == OP_IDLE) begin
			if (q_ids.size() == 0) begin
				run_valid[c] = 1'b0;
				waiting[c] = 1'b1;
				return;
			end
			dispatch_cpu(c);
			return;
		end
		if (op == OP_PREEMPT && run_valid[c]) begin
			if (q_ids.size() >= QUEUE_DEPTH_DEF) begin
				run_valid[c] = 1'b0;
				push_result(ACT_FULL, c, run_ids[c], SLICE_NONE);
				return;
			end
			q_ids.push_back(run_ids[c]);
			q_times.push_back(rem);
		end
		run_valid[c] = 1'b0;
		dispatch_cpu(c);
	endfunction

	// valid stays high after an accept until the next item or an idle gap
	task automatic send_event(input logic [2:0] op, input logic [2:0] c,
	                          input logic [7:0] pid, input logic [15:0] rem);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.cpu_index <= c;
		in_ch.proc_id <= pid;
		in_ch.remaining <= rem;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_event(op_t'(op), c, pid, rem);
		@(negedge clk);
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [16:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			CFG_SRTF: srtf = value[0];
			CFG_NCPU: ncpu = value[3:0];
			default: slice_len = value;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input logic s, input logic [3:0] n,
	                         input logic [16:0] sl);
		settle();
		write_reg(CFG_SRTF, {16'd0, s});
		write_reg(CFG_NCPU, {13'd0, n});
		write_reg(CFG_SLICE, sl);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_event(input int bias_wake);
		logic [2:0] op;
		int r;
		r = $urandom_range(99);
		if (r < bias_wake) op = OP_WAKE;
		else if (r < 97) op = 3'($urandom_range(3));
		else op = 3'($urandom_range(7, 5));
		send_event(op, 3'($urandom), 8'($urandom),
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
	endtask

	task automatic test_directed_fifo();
		configure(1'b0, 4'd2, 17'd0);
		send_event(OP_IDLE, 0, 0, 0);
		send_event(OP_IDLE, 1, 0, 0);
		send_event(OP_WAKE, 0, 8'hff, 16'hffff);
		send_event(OP_WAKE, 0, 8'h00, 16'h0000);
		send_event(OP_WAKE, 0, 8'h55, 16'h1234);
		send_event(OP_PREEMPT, 0, 0, 16'hffff);
		send_event(OP_YIELD, 1, 0, 0);
		send_event(OP_TERM, 0, 0, 0);
		send_event(OP_TERM, 1, 0, 0);
		send_event(OP_TERM, 0, 0, 0);
		send_event(OP_PREEMPT, 0, 0, 5);
		send_event(OP_YIELD, 7, 0, 0);
		send_event(3'd5, 0, 0, 0);
		send_event(3'd7, 0, 0, 0);
	endtask

	task automatic test_directed_srtf();
		configure(1'b1, 4'd2, 17'h1ffff);
		send_event(OP_WAKE, 0, 8'd1, 16'd50);
		send_event(OP_WAKE, 0, 8'd2, 16'd10);
		send_event(OP_WAKE, 0, 8'd3, 16'd10);
		send_event(OP_IDLE, 0, 0, 0);
		send_event(OP_IDLE, 1, 0, 0);
		send_event(OP_WAKE, 0, 8'd4, 16'd1);
		send_event(OP_PREEMPT, 1, 0, 16'd40);
		send_event(OP_WAKE, 0, 8'd5, 16'd60);
	endtask

	task automatic test_full_queue();
		configure(1'b0, 4'd1, 17'd65535);
		send_event(OP_WAKE, 0, 8'd9, 16'd3);
		send_event(OP_IDLE, 0, 0, 0);
		for (int i = 0; i < 33; i++) send_event(OP_WAKE, 0, 8'(i + 20), 16'(i));
		send_event(OP_PREEMPT, 0, 0, 16'd7);
		send_event(OP_IDLE, 0, 0, 0);
		for (int i = 0; i < 34; i++) send_event(OP_TERM, 0, 0, 0);
	endtask

	task automatic test_backpressure();
		configure(1'b1, 4'd8, 17'd100);
		hold_cycles = 300;
		for (int i = 0; i < 20; i++) random_event(40);
	endtask

	task automatic test_random(input int count);
		logic [16:0] sl;
		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(3))
				0: sl = 17'h1ffff;
				1: sl = 17'h10000 | 17'($urandom);
				2: sl = 17'd65535;
				default: sl = 17'($urandom_range(65535));
			endcase
			configure(p[0], (p == 2) ? 4'd0 : (p == 3) ? 4'd15 : 4'($urandom_range(8, 1)),
				sl);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 47; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 47; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			for (int i = 0; i < count / 6; i++) random_event(45);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver side
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else
				out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0)
				report("result item with none expected");
			else begin
				e = expected_results.pop_front();
				if (out_ch.action !== e.action)
					report($sformatf("action %0d, expected %0d", out_ch.action, e.action));
				if (out_ch.target_cpu !== e.target_cpu)
					report($sformatf("target_cpu %0d, expected %0d", out_ch.target_cpu,
						e.target_cpu));
				if (out_ch.chosen_id !== e.chosen_id)
					report($sformatf("chosen_id %0d, expected %0d", out_ch.chosen_id,
						e.chosen_id));
				if (out_ch.granted_slice !== e.granted_slice)
					report($sformatf("granted_slice %h, expected %h", out_ch.granted_slice,
						e.granted_slice));
			end
		end
	end

	initial begin
		#100000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.cpu_index = '0;
		in_ch.proc_id = '0;
		in_ch.remaining = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		srtf = 1'b0;
		ncpu = 4'd1;
		slice_len = SLICE_NONE;
		for (int i = 0; i < 8; i++) begin
			run_valid[i] = 1'b0;
			waiting[i] = 1'b0;
			run_ids[i] = '0;
			run_times[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (5) @(negedge clk);
		test_directed_fifo();
		test_directed_srtf();
		test_full_queue();
		test_backpressure();
		test_random(480);
		settle();
		if (errors == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
